// ----- src/halfband_decimator_11tap_core_assert.svh -----
// Assertion macros shared by the half-band decimator RTL.
`ifndef HALFBAND_DECIMATOR_11TAP_CORE_ASSERT_SVH
`define HALFBAND_DECIMATOR_11TAP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdb assertion failed");

`endif

// ----- src/hdb_pkg.sv -----
// Constants shared by the half-band decimator modules.
package hdb_pkg;

    localparam int TAP_COUNT  = 11;
    localparam int HIST_DEPTH = TAP_COUNT - 1;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 15;

    // Q1.15 kernel, odd taps other than the centre tap are zero
    localparam logic signed [COEF_W-1:0] COEF_H0  = 16'sd598;
    localparam logic signed [COEF_W-1:0] COEF_H2  = -16'sd3806;
    localparam logic signed [COEF_W-1:0] COEF_H4  = 16'sd11400;
    localparam logic signed [COEF_W-1:0] COEF_MID = 16'sd16384;

endpackage

// ----- src/halfband_decimator_11tap_core.sv -----
// Top level of the 11-tap half-band decimate-by-two filter.
//
//   Channel   Handshake                     Payload
//   sample    sample_valid / sample_ready   sample_in
//   result    result_valid / result_ready   filtered_sample, clipped
//
// Takes one sample every cycle while sample_ready is high; every second
// sample (the first of each pair) launches one result, which is registered
// through the four-stage pre-add / multiply / sum / round pipeline.
// A stalled result backs up stage by stage; sample_ready drops only when all
// four stages hold results. Reset zeroes the delay line and the pair phase.
module halfband_decimator_11tap_core import hdb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
    output logic                           clipped
);

    logic                           sample_fire;
    logic                           start_valid;
    logic                           start_ready;
    logic                           pair_phase_reg;
    logic                           pair_phase_next;
    logic signed [SAMPLE_WIDTH-1:0] hist [HIST_DEPTH];

    // Accept a request whenever the pipeline head can take one; odd samples
    // only advance the delay line.
    assign sample_ready = start_ready;
    assign sample_fire  = sample_valid && sample_ready;
    assign start_valid  = sample_valid && !pair_phase_reg;

    // Delay line: cell 0 holds x[n-1], the last cell x[n-10].
    for (genvar i = 0; i < HIST_DEPTH; i++)
    begin : g_tap
        if (i == 0)
        begin : g_head
            hdb_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (sample_fire),
                .d        (sample_in),
                .q        (hist[i])
            );
        end
        else
        begin : g_body
            hdb_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (sample_fire),
                .d        (hist[i-1]),
                .q        (hist[i])
            );
        end
    end

    // Toggle the pair phase on every accepted sample.
    always_comb
    begin
        pair_phase_next = sample_fire ? !pair_phase_reg : pair_phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_phase_reg <= 1'b0;
        end
        else
        begin
            pair_phase_reg <= pair_phase_next;
        end
    end

    hdb_mac_pipe #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mac (
        .clk             (clk),
        .rst_n           (rst_n),
        .start_valid     (start_valid),
        .start_ready     (start_ready),
        .x               (sample_in),
        .hist            (hist),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .filtered_sample (filtered_sample),
        .clipped         (clipped)
    );

endmodule

// ----- src/hdb_tap_cell.sv -----
// One delay-line cell: holds a sample and hands it to the next cell on each shift.
module hdb_tap_cell import hdb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           shift_en,
    input  logic signed [SAMPLE_WIDTH-1:0] d,
    output logic signed [SAMPLE_WIDTH-1:0] q
);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_next;

    always_comb
    begin
        sample_next = shift_en ? d : sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign q = sample_reg;

endmodule

// ----- src/hdb_mac_pipe.sv -----
// Four-stage pre-add, multiply, sum and round/saturate pipeline with per-stage flow control.
module hdb_mac_pipe import hdb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start_valid,
    output logic                           start_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic signed [SAMPLE_WIDTH-1:0] hist [HIST_DEPTH],
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
    output logic                           clipped
);

`include "halfband_decimator_11tap_core_assert.svh"

    localparam int SUM_W = SAMPLE_WIDTH + 1;
    localparam int ACC_W = SAMPLE_WIDTH + COEF_W + 1;
    localparam int Y_W   = ACC_W - FRAC_BITS;
    localparam int PAD_W = Y_W - SAMPLE_WIDTH + 1;

    localparam logic signed [Y_W-1:0] Y_MAX = {{PAD_W{1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {{PAD_W{1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    logic signed [SUM_W-1:0]        p0_reg, p2_reg, p4_reg;
    logic signed [SUM_W-1:0]        p0_next, p2_next, p4_next;
    logic signed [SAMPLE_WIDTH-1:0] pm_reg;
    logic signed [ACC_W-1:0]        q0_reg, q2_reg, q4_reg, qm_reg;
    logic signed [ACC_W-1:0]        q0_next, q2_next, q4_next, qm_next;
    logic signed [ACC_W-1:0]        sa_reg, sb_reg, sa_next, sb_next;
    logic signed [ACC_W-1:0]        acc;
    logic signed [Y_W-1:0]          y;
    logic signed [SAMPLE_WIDTH-1:0] fs_reg, fs_next;
    logic                           clip_reg, clip_next;

    // a stage moves when it is empty or its successor moves
    assign r4 = !v4_reg || result_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign start_ready = r1;

    always_comb
    begin
        // symmetric pairs: x[n]+x[n-10], x[n-2]+x[n-8], x[n-4]+x[n-6]
        p0_next = SUM_W'(x) + SUM_W'(hist[9]);
        p2_next = SUM_W'(hist[1]) + SUM_W'(hist[7]);
        p4_next = SUM_W'(hist[3]) + SUM_W'(hist[5]);

        q0_next = p0_reg * COEF_H0;
        q2_next = p2_reg * COEF_H2;
        q4_next = p4_reg * COEF_H4;
        qm_next = pm_reg * COEF_MID;

        sa_next = q0_reg + q2_reg;
        sb_next = q4_reg + qm_reg;

        acc = sa_reg + sb_reg + ROUND_BIAS;
        y   = acc[ACC_W-1:FRAC_BITS];
        if (y > Y_MAX)
        begin
            fs_next   = Y_MAX[SAMPLE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else if (y < Y_MIN)
        begin
            fs_next   = Y_MIN[SAMPLE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            fs_next   = y[SAMPLE_WIDTH-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= start_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && start_valid)
        begin
            p0_reg <= p0_next;
            p2_reg <= p2_next;
            p4_reg <= p4_next;
            pm_reg <= hist[4];
        end
        if (r2 && v1_reg)
        begin
            q0_reg <= q0_next;
            q2_reg <= q2_next;
            q4_reg <= q4_next;
            qm_reg <= qm_next;
        end
        if (r3 && v2_reg)
        begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
        if (r4 && v3_reg)
        begin
            fs_reg   <= fs_next;
            clip_reg <= clip_next;
        end
    end

    assign result_valid    = v4_reg;
    assign filtered_sample = fs_reg;
    assign clipped         = clip_reg;

    `HDB_ASSERT_NEXT(a_start_lands, clk, rst_n, start_valid && start_ready, v1_reg)
    `HDB_ASSERT_NEXT(a_s3_stall_holds, clk, rst_n, v3_reg && !r3, v3_reg && $stable(sa_reg) && $stable(sb_reg))
    `HDB_ASSERT_IMPL(a_clip_at_rail, clk, rst_n, v4_reg && clip_reg, fs_reg == Y_MAX[SAMPLE_WIDTH-1:0] || fs_reg == Y_MIN[SAMPLE_WIDTH-1:0])

endmodule

// ----- tb/halfband_decimator_11tap_core_test.sv -----
// Self-checking testbench for the 11-tap half-band decimate-by-two filter core.

typedef logic signed [15:0] sample_t;

// Tracks the filter state and queues the filtered samples the core owes us.
class decimated_output_tracker;
    sample_t history [10];
    bit      odd_phase;
    sample_t owed_sample [$];
    bit      owed_clip [$];

    function new();
        foreach (history[i])
            history[i] = '0;
        odd_phase = 1'b0;
    endfunction

    // Note an accepted input sample; the first of each pair yields one result.
    function void take_sample(sample_t x);
        longint  acc;
        longint  rounded;
        bit      clip;
        sample_t narrow;
        int      i;
        if (!odd_phase) begin
            acc = longint'(hdb_pkg::COEF_H0) * (longint'(x) + longint'(history[9]))
                + longint'(hdb_pkg::COEF_H2) * (longint'(history[1]) + longint'(history[7]))
                + longint'(hdb_pkg::COEF_H4) * (longint'(history[3]) + longint'(history[5]))
                + longint'(hdb_pkg::COEF_MID) * longint'(history[4]);
            rounded = (acc + (longint'(1) <<< (hdb_pkg::FRAC_BITS - 1)))
                      >>> hdb_pkg::FRAC_BITS;
            clip = 1'b0;
            if (rounded > 32767) begin
                rounded = 32767;
                clip    = 1'b1;
            end
            else if (rounded < -32768) begin
                rounded = -32768;
                clip    = 1'b1;
            end
            narrow = rounded[15:0];
            owed_sample.push_back(narrow);
            owed_clip.push_back(clip);
        end
        for (i = 9; i > 0; i--)
            history[i] = history[i-1];
        history[0] = x;
        odd_phase  = ~odd_phase;
    endfunction

    // Compare a delivered result with the oldest owed one; empty string on match.
    function string match_output(sample_t got, logic got_clip);
        sample_t want;
        bit      want_clip;
        string   msg;
        if (owed_sample.size() == 0)
            return $sformatf("unexpected result %0d clipped=%0b", got, got_clip);
        want      = owed_sample.pop_front();
        want_clip = owed_clip.pop_front();
        msg       = "";
        if (got !== want)
            msg = $sformatf("filtered_sample %0d, expected %0d", got, want);
        if (got_clip !== want_clip)
            msg = {msg, (msg == "") ? "" : "; ",
                   $sformatf("clipped %0b, expected %0b", got_clip, want_clip)};
        return msg;
    endfunction

    function int pending();
        return owed_sample.size();
    endfunction
endclass

module halfband_decimator_11tap_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hdb_pkg::*;

    localparam sample_t SAMPLE_HI       = 16'sh7FFF;
    localparam sample_t SAMPLE_LO       = 16'sh8000;
    localparam int      DIRECTED_ITEMS  = 25;
    localparam int      RANDOM_ITEMS    = 1350;
    localparam int      HOLD_OFF_AFTER  = 400;
    localparam int      HOLD_OFF_CYCLES = 120;
    localparam int      STALL_LIMIT     = 2000;
    localparam int      DRAIN_CYCLES    = 12;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_ready;
    sample_t sample_in;
    logic    result_valid;
    logic    result_ready;
    sample_t filtered_sample;
    logic    clipped;

    decimated_output_tracker tracker;

    int error_count  = 0;
    int samples_sent = 0;
    int stall_cycles = 0;
    bit held_off     = 1'b0;

    halfband_decimator_11tap_core #(
        .SAMPLE_WIDTH (16)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample_in       (sample_in),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .filtered_sample (filtered_sample),
        .clipped         (clipped)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Offer one sample request and hold it until the core takes it.
    // Valid stays high on return so back-to-back requests need no extra edge.
    task automatic push_sample(input sample_t value);
        sample_valid <= 1'b1;
        sample_in    <= value;
        do
            @(posedge clk);
        while (!sample_ready);
        samples_sent++;
    endtask

    // Drop valid for a gap of the given length.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            sample_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Mix of full-range values, small values, extremes and values near the rails.
    function automatic sample_t random_sample();
        logic [31:0] raw;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        raw  = $urandom();
        case (pick)
            5, 6:    raw = $urandom_range(0, 512) - 256;
            7:       raw = raw[0] ? SAMPLE_HI : SAMPLE_LO;
            8:       raw = raw[0] ? SAMPLE_HI - $urandom_range(0, 63)
                                  : SAMPLE_LO + $urandom_range(0, 63);
            9:       raw = raw[0] ? 32'hFFFF_FFFF : 32'h0;
            default: ;
        endcase
        return raw[15:0];
    endfunction

    // Eleven samples lined up against the kernel signs so the emitted sum
    // lands beyond the rail. Positive taps get one extreme, the negative
    // taps the other; zero-weight taps carry zeros or random filler.
    // Jitter pulls the extremes inward so that some patterns only come close.
    task automatic send_clip_pattern(input bit negative, input int jitter);
        sample_t hi;
        sample_t lo;
        sample_t swap;
        int      k;
        // Align to the emitting phase so the eleventh sample produces the result.
        if (samples_sent % 2 != 0)
            push_sample(random_sample());
        for (k = 0; k < 11; k++) begin
            hi = SAMPLE_HI - $urandom_range(0, jitter);
            lo = SAMPLE_LO + $urandom_range(0, jitter);
            if (negative) begin
                swap = hi;
                hi   = lo;
                lo   = swap;
            end
            case (k)
                0, 4, 5, 6, 10: push_sample(hi);
                2, 8:           push_sample(lo);
                default:        push_sample((jitter == 0) ? sample_t'(0) : random_sample());
            endcase
        end
    endtask

    // Watch both channels at every edge: feed accepted requests into the
    // tracker, check delivered results, and kill the run if traffic dies.
    always @(posedge clk) begin : watch
        string verdict;
        bit    moved;
        if (rst_n) begin
            moved = 1'b0;
            if (sample_valid && sample_ready) begin
                tracker.take_sample(sample_in);
                moved = 1'b1;
            end
            if (result_valid && result_ready) begin
                verdict = tracker.match_output(filtered_sample, clipped);
                if (verdict != "")
                    report_mismatch(verdict);
                moved = 1'b1;
            end
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: stall in stretches of varying density, and once hold off
    // long enough that all four pipeline stages fill and sample_ready drops.
    initial begin : receiver
        int unsigned mode;
        int unsigned stretch;
        result_ready <= 1'b0;
        forever begin
            if (!held_off && samples_sent >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                repeat (HOLD_OFF_CYCLES) begin
                    @(posedge clk);
                    result_ready <= 1'b0;
                end
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(5, 40);
            repeat (stretch) begin
                @(posedge clk);
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= $urandom_range(0, 1);
                    2:       result_ready <= ($urandom_range(0, 7) != 0);
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Sample side: reset, directed patterns, then random bursts with gaps.
    initial begin : sender
        tracker = new();
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample_in    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start-up with zero history, then clip high and clip low.
        send_clip_pattern(1'b0, 0);
        send_clip_pattern(1'b1, 0);
        push_sample(SAMPLE_HI);
        push_sample(SAMPLE_LO);
        pause_sender(3);

        while (samples_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                send_clip_pattern($urandom_range(0, 1), $urandom_range(0, 3000));
            else
                repeat ($urandom_range(1, 32)) push_sample(random_sample());
            // Leave some bursts back to back so long stretches run without gaps.
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 7));
        end

        sample_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            report_mismatch("results still outstanding at end of run");

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
